// ===== sv/msh_pkg.sv =====
package msh_pkg;

  // fixed field and register widths
  localparam int Z_W       = 64;
  localparam int ORG_W     = 32;
  localparam int STEP_W    = 31;
  localparam int ITER_W    = 16;
  localparam int ROW_W     = 12;
  localparam int SHADE_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int MOD_W     = 5;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd5;

  // register values after reset
  localparam logic [ORG_W-1:0]  RST_REAL_ORIGIN = 32'hD000_0000;
  localparam logic [ORG_W-1:0]  RST_IMAG_ORIGIN = 32'hE000_0000;
  localparam logic [STEP_W-1:0] RST_REAL_STEP   = 31'd2097152;
  localparam logic [STEP_W-1:0] RST_IMAG_STEP   = 31'd4194304;
  localparam logic [ITER_W-1:0] RST_ITER_LIMIT  = 16'd50;
  localparam logic [ROW_W-1:0]  RST_ROW_WIDTH   = 12'd80;

  // shade ramp
  localparam logic [MOD_W-1:0]   RAMP_LAST  = 5'd18;
  localparam logic [SHADE_W-1:0] CHAR_SPACE = 7'h20;

  // operand pairs for the shared multiplier
  typedef enum logic [1:0] {
    MSEL_ZY_ZX,
    MSEL_ZX_ZX,
    MSEL_ZY_ZY
  } mul_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load_item;
    logic     div_step;
    logic     calc_coord;
    logic     upd_zx;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     upd_zy;
    logic     wr_xsq;
    logic     wr_ysq;
    logic     inc_count;
    logic     out_load;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic iter_go;
    logic mul_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [SHADE_W-1:0] shade_ramp(input logic [MOD_W-1:0] pos);
    logic [SHADE_W-1:0] ch;
    case (pos)
      5'd0:    ch = 7'h20;
      5'd1:    ch = 7'h2E;
      5'd2:    ch = 7'h2C;
      5'd3:    ch = 7'h2D;
      5'd4:    ch = 7'h7E;
      5'd5:    ch = 7'h6F;
      5'd6:    ch = 7'h3A;
      5'd7:    ch = 7'h3B;
      5'd8:    ch = 7'h2A;
      5'd9:    ch = 7'h3D;
      5'd10:   ch = 7'h3E;
      5'd11:   ch = 7'h3C;
      5'd12:   ch = 7'h21;
      5'd13:   ch = 7'h3F;
      5'd14:   ch = 7'h48;
      5'd15:   ch = 7'h58;
      5'd16:   ch = 7'h23;
      5'd17:   ch = 7'h24;
      5'd18:   ch = 7'h40;
      default: ch = 7'h20;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/msh_fxmul.sv =====
module msh_fxmul
  import msh_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [Z_W-1:0] a_i,
  input  logic signed [Z_W-1:0] b_i,
  output logic                  done_o,
  output logic signed [Z_W-1:0] res_o
);

  localparam int HW = Z_W / 2;
  localparam int PW = 2 * Z_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ACC  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  localparam logic [Z_W-1:0] SAT_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0] SAT_MIN = {1'b1, {(Z_W-1){1'b0}}};

  logic [1:0]     phase_q, phase_d;
  logic [1:0]     step_q;
  logic           done_q;
  logic [Z_W-1:0] xm_q, ym_q;
  logic           neg_q;
  logic [PW-1:0]  acc_q;
  logic [Z_W-1:0] res_q;

  logic [Z_W-1:0] a_mag, b_mag;
  logic [HW-1:0]  op_x, op_y;
  logic [Z_W-1:0] pp;
  logic [PW-1:0]  pp_place;
  logic [PW-1:0]  q_full;
  logic           hi_nz, rem_nz;
  logic [Z_W-1:0] res_d;

  // operand magnitudes, the most negative value maps to 2^63
  assign a_mag = a_i[Z_W-1] ? (Z_W'(0) - a_i) : a_i;
  assign b_mag = b_i[Z_W-1] ? (Z_W'(0) - b_i) : b_i;

  // one 32x32 partial product per cycle
  always_comb begin
    case (step_q)
      2'd0: begin
        op_x = xm_q[HW-1:0];
        op_y = ym_q[HW-1:0];
      end
      2'd1: begin
        op_x = xm_q[HW-1:0];
        op_y = ym_q[Z_W-1:HW];
      end
      2'd2: begin
        op_x = xm_q[Z_W-1:HW];
        op_y = ym_q[HW-1:0];
      end
      default: begin
        op_x = xm_q[Z_W-1:HW];
        op_y = ym_q[Z_W-1:HW];
      end
    endcase
  end

  assign pp = op_x * op_y;

  always_comb begin
    case (step_q)
      2'd0:       pp_place = {{Z_W{1'b0}}, pp};
      2'd1, 2'd2: pp_place = {{HW{1'b0}}, pp, {HW{1'b0}}};
      default:    pp_place = {pp, {Z_W{1'b0}}};
    endcase
  end

  // scale down with floor rounding and saturate
  assign q_full = acc_q >> FRAC_BITS;
  assign hi_nz  = |q_full[PW-1:Z_W-1];
  assign rem_nz = |acc_q[FRAC_BITS-1:0];

  always_comb begin
    if (!neg_q) begin
      res_d = hi_nz ? SAT_MAX : q_full[Z_W-1:0];
    end else if (hi_nz) begin
      res_d = SAT_MIN;
    end else begin
      res_d = ~{1'b0, q_full[Z_W-2:0]} + {{(Z_W-1){1'b0}}, ~rem_nz};
    end
  end

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_ACC;
      PH_ACC:  if (step_q == 2'd3) phase_d = PH_FIN;
      PH_FIN:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == PH_FIN);
      if (phase_q == PH_IDLE) begin
        step_q <= 2'd0;
      end else if (phase_q == PH_ACC) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  // operand, accumulator and result registers
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      xm_q  <= a_mag;
      ym_q  <= b_mag;
      neg_q <= a_i[Z_W-1] ^ b_i[Z_W-1];
      acc_q <= '0;
    end else if (phase_q == PH_ACC) begin
      acc_q <= acc_q + pp_place;
    end
    if (phase_q == PH_FIN) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/msh_datapath.sv =====
module msh_datapath
  import msh_pkg::*;
#(
  parameter int FRAC_BITS  = 28,
  parameter int INDEX_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [INDEX_BITS-1:0] pixel_index_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [INDEX_BITS-1:0] out_index_o,
  output logic [SHADE_W-1:0]    shade_char_o,
  output logic [ITER_W-1:0]     orbit_count_o,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o
);

  localparam int PROD_W = INDEX_BITS + STEP_W;
  localparam logic [Z_W:0] FOUR = {{(Z_W-2){1'b0}}, 3'b100} << FRAC_BITS;

  // configuration registers
  logic [ORG_W-1:0]  real_origin_q, imag_origin_q;
  logic [STEP_W-1:0] real_step_q, imag_step_q;
  logic [ITER_W-1:0] iter_limit_q;
  logic [ROW_W-1:0]  row_width_q;

  // item registers
  logic [INDEX_BITS-1:0] idx_q;
  logic [ROW_W-1:0]      rem_q;
  logic [INDEX_BITS-1:0] quo_q;
  logic signed [Z_W-1:0] cx_q, cy_q, zx_q, zy_q, xsq_q, ysq_q;
  logic [ITER_W-1:0]     count_q;
  logic [MOD_W-1:0]      mod_q;

  // output register
  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] out_index_q;
  logic [SHADE_W-1:0]    shade_q;
  logic [ITER_W-1:0]     out_count_q;

  logic                      div_bit;
  logic [ROW_W+1:0]          trial;
  logic [INDEX_BITS+ROW_W-1:0] rem_ext;
  logic [INDEX_BITS-1:0]     col, row;
  logic [PROD_W-1:0]         prod_x, prod_y;
  logic signed [Z_W-1:0]     cx_d, cy_d;
  logic [Z_W:0]              sq_sum;
  logic signed [Z_W-1:0]     mul_a, mul_b, mul_res;
  logic                      mul_done;
  logic [SHADE_W-1:0]        shade_d;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= RST_REAL_ORIGIN;
      imag_origin_q <= RST_IMAG_ORIGIN;
      real_step_q   <= RST_REAL_STEP;
      imag_step_q   <= RST_IMAG_STEP;
      iter_limit_q  <= RST_ITER_LIMIT;
      row_width_q   <= RST_ROW_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REAL_ORIGIN: real_origin_q <= cfg_data_i;
        REG_IMAG_ORIGIN: imag_origin_q <= cfg_data_i;
        REG_REAL_STEP:   real_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_IMAG_STEP:   imag_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_ITER_LIMIT:  iter_limit_q  <= cfg_data_i[ITER_W-1:0];
        REG_ROW_WIDTH:   row_width_q   <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divide step, one quotient bit per cycle
  assign div_bit = quo_q[INDEX_BITS-1];
  assign trial   = {1'b0, rem_q, div_bit} - {2'b00, row_width_q};

  // column and row, a zero row width puts the whole index in the column
  assign rem_ext = {{INDEX_BITS{1'b0}}, rem_q};
  assign col = (row_width_q == '0) ? idx_q : rem_ext[INDEX_BITS-1:0];
  assign row = (row_width_q == '0) ? '0 : quo_q;

  // point on the complex plane
  assign prod_x = col * real_step_q;
  assign prod_y = row * imag_step_q;
  assign cx_d = {{(Z_W-ORG_W){real_origin_q[ORG_W-1]}}, real_origin_q}
              + {{(Z_W-PROD_W){1'b0}}, prod_x};
  assign cy_d = {{(Z_W-ORG_W){imag_origin_q[ORG_W-1]}}, imag_origin_q}
              + {{(Z_W-PROD_W){1'b0}}, prod_y};

  // escape test, both squares are never negative
  assign sq_sum = {1'b0, xsq_q} + {1'b0, ysq_q};

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_ZY_ZX: begin
        mul_a = zy_q;
        mul_b = zx_q;
      end
      MSEL_ZX_ZX: begin
        mul_a = zx_q;
        mul_b = zx_q;
      end
      MSEL_ZY_ZY: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
      default: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
    endcase
  end

  msh_fxmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fxmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // item datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      idx_q   <= pixel_index_i;
      quo_q   <= pixel_index_i;
      rem_q   <= '0;
      zx_q    <= '0;
      zy_q    <= '0;
      xsq_q   <= '0;
      ysq_q   <= '0;
      count_q <= '0;
      mod_q   <= '0;
    end else begin
      if (cmd_i.div_step) begin
        if (!trial[ROW_W+1]) begin
          rem_q <= trial[ROW_W-1:0];
          quo_q <= {quo_q[INDEX_BITS-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[ROW_W-2:0], div_bit};
          quo_q <= {quo_q[INDEX_BITS-2:0], 1'b0};
        end
      end
      if (cmd_i.calc_coord) begin
        cx_q <= cx_d;
        cy_q <= cy_d;
      end
      if (cmd_i.upd_zx) begin
        zx_q <= xsq_q - ysq_q + cx_q;
      end
      if (cmd_i.upd_zy) begin
        zy_q <= {mul_res[Z_W-2:0], 1'b0} + cy_q;
      end
      if (cmd_i.wr_xsq) begin
        xsq_q <= mul_res;
      end
      if (cmd_i.wr_ysq) begin
        ysq_q <= mul_res;
      end
      if (cmd_i.inc_count) begin
        count_q <= count_q + 1'b1;
        mod_q   <= (mod_q == RAMP_LAST) ? '0 : mod_q + 1'b1;
      end
    end
  end

  // shade for the finished pixel
  assign shade_d = (count_q == iter_limit_q) ? CHAR_SPACE : shade_ramp(mod_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= idx_q;
      shade_q     <= shade_d;
      out_count_q <= count_q;
    end
  end

  assign stat_o.iter_go  = (count_q < iter_limit_q) && (sq_sum < FOUR);
  assign stat_o.mul_done = mul_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign shade_char_o  = shade_q;
  assign orbit_count_o = out_count_q;

endmodule

// ===== sv/msh_ctrl.sv =====
module msh_ctrl
  import msh_pkg::*;
#(
  parameter int INDEX_BITS = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam int CNT_W = $clog2(INDEX_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(INDEX_BITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_COORD = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MUL_A = 3'd4;
  localparam logic [2:0] ST_MUL_B = 3'd5;
  localparam logic [2:0] ST_MUL_C = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // sequencing of one pixel
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_COORD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_COORD: begin
        cmd_o.calc_coord = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // zx takes its new value while the multiplier latches the old one
        if (stat_i.iter_go) begin
          cmd_o.upd_zx    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MSEL_ZY_ZX;
          state_d = ST_MUL_A;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_sel = MSEL_ZX_ZX;
        if (stat_i.mul_done) begin
          cmd_o.upd_zy    = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        cmd_o.mul_sel = MSEL_ZY_ZY;
        if (stat_i.mul_done) begin
          cmd_o.wr_xsq    = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        cmd_o.mul_sel = MSEL_ZY_ZY;
        if (stat_i.mul_done) begin
          cmd_o.wr_ysq    = 1'b1;
          cmd_o.inc_count = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== sv/mandelbrot_pixel_shader_top.sv =====
// channel   direction  handshake                  payload
// config    in         cfg_we_i                   cfg_idx_i, cfg_data_i
// pixel     in         in_valid_i / in_stall_o    pixel_index_i
// result    out        out_valid_o / out_stall_i  out_index_o, shade_char_o, orbit_count_o
//
// each pixel passes the serial row divider, the point calculation and then the orbit steps
// until escape or the iteration limit, each orbit step being a test plus three products on
// the one shared multiplier, which builds them from 32x32 partial products
// a finished result sits in the output register, a new pixel is taken meanwhile
// reset loads the register defaults and empties the output register
module mandelbrot_pixel_shader_top
  import msh_pkg::*;
#(
  parameter int FRAC_BITS  = 28,
  parameter int INDEX_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] pixel_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [INDEX_BITS-1:0] out_index_o,
  output logic [SHADE_W-1:0]    shade_char_o,
  output logic [ITER_W-1:0]     orbit_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  msh_ctrl #(
    .INDEX_BITS(INDEX_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // registers, divider, orbit arithmetic and output stage
  msh_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_index_i(pixel_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_index_o  (out_index_o),
    .shade_char_o (shade_char_o),
    .orbit_count_o(orbit_count_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
